/* design/tbbd_pkg.sv */
// Shared types and constants for the two-bit block dequantizer.
// No dependencies; used by every module of the block.
package tbbd_pkg;

  localparam int unsigned NumBeats = 16;
  localparam int unsigned MagW     = 48;
  localparam logic [7:0]  ExpBase  = 8'd149;   // 127 + 47 - 25
  localparam logic [4:0]  ExpOnes  = 5'h1F;

  // one result in flight out of the serializer
  typedef struct packed {
    logic        ss;
    logic        sm;
    logic [4:0]  es;
    logic [4:0]  em;
    logic [10:0] ms;
    logic [10:0] mm;
    logic [3:0]  ls;
    logic [3:0]  lm;
    logic [1:0]  q;
    logic        special;
    logic [3:0]  pos;
    logic        last;
  } beat_t;

  // aligned, exact difference
  typedef struct packed {
    logic              sign;
    logic              zero_sign;
    logic [4:0]        emin;
    logic [MagW-1:0]   mag;
    logic              special;
    logic [3:0]        pos;
    logic              last;
  } sum_t;

endpackage

/* design/tbbd_serializer.sv */
// Holds one accepted request and hands out its 16 bytes, one beat a cycle while not stalled.
// Depends on tbbd_pkg.
module tbbd_serializer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [15:0]          scale_half_i,
  input  logic [15:0]          minimum_half_i,
  input  logic [7:0]           subscale_byte_i,
  input  logic [127:0]         quant_bytes_i,
  input  logic [1:0]           bit_pair_i,
  output logic                 beat_valid_o,
  output tbbd_pkg::beat_t      beat_o
);

  logic         busy_q, busy_d;
  logic [3:0]   cnt_q, cnt_d;
  logic [15:0]  sh_q, mh_q;
  logic [7:0]   sub_q;
  logic [127:0] qb_q;
  logic [1:0]   pick_q;
  logic         last_beat, accept;
  logic [7:0]   cur_byte;
  logic [4:0]   ex_s, ex_m;

  assign last_beat  = (cnt_q == 4'(tbbd_pkg::NumBeats - 1));
  assign in_ready_o = ~busy_q | (en_i & last_beat);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (busy_q && en_i) begin
      cnt_d = cnt_q + 4'd1;
      if (last_beat) busy_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sh_q   <= scale_half_i;
      mh_q   <= minimum_half_i;
      sub_q  <= subscale_byte_i;
      qb_q   <= quant_bytes_i;
      pick_q <= bit_pair_i;
    end
  end

  assign cur_byte = qb_q[{cnt_q, 3'b000} +: 8];
  assign ex_s     = sh_q[14:10];
  assign ex_m     = mh_q[14:10];

  always_comb begin
    beat_o.ss      = sh_q[15];
    beat_o.sm      = mh_q[15];
    // subnormal halves sit at exponent one without the hidden bit
    beat_o.es      = (ex_s == 5'd0) ? 5'd1 : ex_s;
    beat_o.em      = (ex_m == 5'd0) ? 5'd1 : ex_m;
    beat_o.ms      = {(ex_s != 5'd0), sh_q[9:0]};
    beat_o.mm      = {(ex_m != 5'd0), mh_q[9:0]};
    beat_o.ls      = sub_q[3:0];
    beat_o.lm      = sub_q[7:4];
    beat_o.q       = 2'(cur_byte >> {pick_q, 1'b0});
    beat_o.special = (ex_s == tbbd_pkg::ExpOnes) | (ex_m == tbbd_pkg::ExpOnes);
    beat_o.pos     = cnt_q;
    beat_o.last    = last_beat;
  end

  assign beat_valid_o = busy_q;

  a_accept_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (!busy_q || (en_i && last_beat)))
    else $error("request taken while a beat is still pending");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !en_i && !accept) |=> ($stable(cnt_q) && busy_q))
    else $error("beat counter moved under stall");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && en_i && last_beat && !accept) |=> !busy_q)
    else $error("serializer did not finish after the last beat");

endmodule

/* design/tbbd_align_add.sv */
// Stages one and two: exact products, then alignment and signed add.
// Depends on tbbd_pkg.
module tbbd_align_add (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  tbbd_pkg::beat_t      beat_i,
  output logic                 valid_o,
  output tbbd_pkg::sum_t       sum_o
);

  localparam int unsigned W = tbbd_pkg::MagW;

  logic        v1_q, v2_q;
  logic [16:0] a_q;
  logic [14:0] b_q;
  logic        sa_q, sbn_q, sp1_q, last1_q;
  logic [4:0]  es_q, em_q;
  logic [3:0]  pos1_q;
  logic [14:0] scl;
  logic [4:0]  emin, sha, shb;
  logic [W-1:0] amag, bmag;
  tbbd_pkg::sum_t sum_d, sum_q;

  assign scl = beat_i.ms * beat_i.ls;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q     <= {2'b00, scl} * {15'd0, beat_i.q};
      b_q     <= beat_i.mm * beat_i.lm;
      sa_q    <= beat_i.ss;
      sbn_q   <= ~beat_i.sm;          // subtracting the minimum part
      es_q    <= beat_i.es;
      em_q    <= beat_i.em;
      sp1_q   <= beat_i.special;
      pos1_q  <= beat_i.pos;
      last1_q <= beat_i.last;
      sum_q   <= sum_d;
    end
  end

  always_comb begin
    emin = (es_q < em_q) ? es_q : em_q;
    sha  = es_q - emin;
    shb  = em_q - emin;
    amag = {{(W - 17){1'b0}}, a_q} << sha;
    bmag = {{(W - 15){1'b0}}, b_q} << shb;
    sum_d.emin      = emin;
    sum_d.zero_sign = sa_q & sbn_q;
    sum_d.special   = sp1_q;
    sum_d.pos       = pos1_q;
    sum_d.last      = last1_q;
    if (sa_q == sbn_q) begin
      sum_d.mag  = amag + bmag;
      sum_d.sign = sa_q;
    end else if (amag >= bmag) begin
      sum_d.mag  = amag - bmag;
      sum_d.sign = sa_q;
    end else begin
      sum_d.mag  = bmag - amag;
      sum_d.sign = sbn_q;
    end
  end

  assign valid_o = v2_q;
  assign sum_o   = sum_q;

endmodule

/* design/tbbd_norm_round.sv */
// Stages three and four: leading-zero normalize, then round to nearest even.
// Depends on tbbd_pkg.
module tbbd_norm_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  tbbd_pkg::sum_t       sum_i,
  output logic                 valid_o,
  output logic [31:0]          value_o,
  output logic [3:0]           pos_o,
  output logic                 last_o
);

  localparam int unsigned W = tbbd_pkg::MagW;

  logic         v3_q, v4_q;
  logic [5:0]   lz;
  logic [W-1:0] norm_q;
  logic [7:0]   exp_q;
  logic         sign_q, zero_q, sp_q, last3_q;
  logic [3:0]   pos3_q;
  logic         rnd;
  logic [30:0]  body;
  logic [31:0]  value_d, value_q;
  logic [3:0]   pos4_q;
  logic         last4_q;

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < W; i++) begin
      if (sum_i.mag[i]) lz = 6'(W - 1 - i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_q  <= sum_i.mag << lz;
      exp_q   <= tbbd_pkg::ExpBase - {2'b00, lz} + {3'b000, sum_i.emin};
      zero_q  <= (sum_i.mag == '0);
      sign_q  <= (sum_i.mag == '0) ? sum_i.zero_sign : sum_i.sign;
      sp_q    <= sum_i.special;
      pos3_q  <= sum_i.pos;
      last3_q <= sum_i.last;
      value_q <= value_d;
      pos4_q  <= pos3_q;
      last4_q <= last3_q;
    end
  end

  always_comb begin
    rnd  = norm_q[W-25] & ((|norm_q[W-26:0]) | norm_q[W-24]);
    body = {exp_q, norm_q[W-2:W-24]} + {30'd0, rnd};
    if (sp_q)        value_d = 32'd0;
    else if (zero_q) value_d = {sign_q, 31'd0};
    else             value_d = {sign_q, body};
  end

  assign valid_o = v4_q;
  assign value_o = value_q;
  assign pos_o   = pos4_q;
  assign last_o  = last4_q;

endmodule

/* design/two_bit_block_dequantizer_core.sv */
// Two-bit block dequantizer, top level.
// Depends on tbbd_pkg, tbbd_serializer, tbbd_align_add, tbbd_norm_round.
//
// Usage:
//  - Slave channel: one request per 16-value sub-group: block scale and
//    minimum (half precision), the sub-group byte, 16 quant bytes and the
//    bit-pair select.
//  - Master channel: 16 single-precision results per request, in byte
//    order; tdata carries value and byte position, tlast marks position 15.
//  - Throughput: one result per cycle while the master channel is not
//    stalled; the serializer takes the next request in the cycle
//    its last beat leaves, so results run back to back.
//  - Pipeline: after the request is taken, the first result passes the
//    product, align/add, normalize and round/pack registers (the
//    serializer presents beat zero straight from the captured request).
//  - Inf/NaN in either half makes all 16 values +0.
//  - Stall: the whole pipeline holds while a result waits and tready is
//    low; nothing is dropped or repeated. The serializer keeps taking a
//    request only when it is free.
//  - Reset: asynchronous, active low; clears all valid bits, no results
//    pending, tready high.
module two_bit_block_dequantizer_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] scale_half, [31:16] minimum_half, [39:32] subscale_byte,
  // [103:40] quant_bytes_low, [167:104] quant_bytes_high, [169:168] bit_pair
  input  logic [175:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] value, [35:32] position
  output logic [39:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  logic            en;
  logic            beat_valid, sum_valid;
  tbbd_pkg::beat_t beat;
  tbbd_pkg::sum_t  sum;
  logic [31:0]     value;
  logic [3:0]      pos;

  // the pipeline advances unless a result sits unread at the output
  assign en = ~m_axis_tvalid | m_axis_tready;

  tbbd_serializer u_ser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .scale_half_i    (s_axis_tdata[15:0]),
    .minimum_half_i  (s_axis_tdata[31:16]),
    .subscale_byte_i (s_axis_tdata[39:32]),
    .quant_bytes_i   (s_axis_tdata[167:40]),
    .bit_pair_i      (s_axis_tdata[169:168]),
    .beat_valid_o    (beat_valid),
    .beat_o          (beat)
  );

  tbbd_align_add u_add (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (beat_valid),
    .beat_i  (beat),
    .valid_o (sum_valid),
    .sum_o   (sum)
  );

  tbbd_norm_round u_rnd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sum_valid),
    .sum_i   (sum),
    .valid_o (m_axis_tvalid),
    .value_o (value),
    .pos_o   (pos),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, pos, value};

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (pos == 4'(tbbd_pkg::NumBeats - 1)))
    else $error("tlast on a position other than fifteen");
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (!m_axis_tvalid || pos == $past(pos) + 4'd1))
    else $error("result positions out of order");
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_valid && !beat.last && s_axis_tready) |-> 1'b0)
    else $error("request taken in the middle of a sub-group");

endmodule

/* tb/two_bit_block_dequantizer_core_tb.sv */
// Testbench for two_bit_block_dequantizer_core: directed table then random requests,
// each of the 16 results checked against a fixed expected value or a bit-exact integer model.
// Depends on tbbd_pkg and the core RTL only.
`timescale 1ns / 100ps

module two_bit_block_dequantizer_core_tb;

  localparam int unsigned NumRandom = 410;
  localparam int unsigned IdleLimit = 5000;

  typedef struct {
    logic [15:0] scale_h;
    logic [15:0] min_h;
    logic [7:0]  sub;
    logic [63:0] q_lo;
    logic [63:0] q_hi;
    logic [1:0]  pair;
    bit          typed;     // value known up front, same for all 16 results
    logic [31:0] typed_val;
  } req_t;

  typedef struct {
    logic [31:0] value;
    logic [3:0]  pos;
    logic        last;
  } deq_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;
  logic         m_axis_tlast;

  deq_res_t pending_q[$];
  req_t     dir_tab[18];
  int       err_count = 0;
  int       res_count = 0;
  int       req_count = 0;
  int       idle_cycles = 0;
  int       special_count = 0;
  longint   cyc = 0;

  two_bit_block_dequantizer_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // scale*sub[3:0]*q - min*sub[7:4], exact integer alignment then a single round to nearest even
  function automatic logic [31:0] dequant_value(logic [15:0] sh, logic [15:0] mh,
                                                logic [7:0] sub, logic [1:0] q);
    longint signed   ms, mm, pa, pb, a, b, d;
    longint unsigned mag, mant, rem, half;
    int              efs, efm, emin, p, sa, ex;
    logic            sgn;
    if (sh[14:10] == tbbd_pkg::ExpOnes || mh[14:10] == tbbd_pkg::ExpOnes) return 32'h0;
    ms  = (sh[14:10] == 0) ? longint'(sh[9:0]) : longint'({1'b1, sh[9:0]});
    mm  = (mh[14:10] == 0) ? longint'(mh[9:0]) : longint'({1'b1, mh[9:0]});
    efs = (sh[14:10] == 0) ? 1 : int'(sh[14:10]);
    efm = (mh[14:10] == 0) ? 1 : int'(mh[14:10]);
    pa  = ms * longint'(sub[3:0]) * longint'(q);
    pb  = mm * longint'(sub[7:4]);
    // both parts zero: sign follows IEEE (-0) - (+0) only
    if (pa == 0 && pb == 0) return {sh[15] & ~mh[15], 31'h0};
    emin = (efs < efm) ? efs : efm;
    a = pa <<< (efs - emin);
    b = pb <<< (efm - emin);
    if (sh[15]) a = -a;
    if (mh[15]) b = -b;
    d = a - b;
    if (d == 0) return 32'h0;   // exact cancellation rounds to +0
    sgn = (d < 0);
    mag = sgn ? longint'(-d) : longint'(d);
    p = 63;
    while (!mag[p]) p--;
    ex = p + emin - 25;
    if (p > 23) begin
      sa   = p - 23;
      mant = mag >> sa;
      rem  = mag & ((64'd1 << sa) - 1);
      half = 64'd1 << (sa - 1);
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant == (64'd1 << 24)) begin
        mant = mant >> 1;
        ex++;
      end
    end else begin
      mant = mag << (23 - p);
    end
    return {sgn, 8'(ex + 127), mant[22:0]};
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] rand_half();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return {1'($urandom), 5'($urandom_range(0, 30)), 10'($urandom)};
    if (r < 95) return 16'($urandom);
    return {1'($urandom), tbbd_pkg::ExpOnes, 10'($urandom)};   // Inf or NaN
  endfunction

  // drive one request and log its 16 expected results on acceptance
  task automatic send_req(input req_t rq);
    logic [7:0] qb;
    logic [1:0] q;
    deq_res_t   er;
    int         g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'h0, rq.pair, rq.q_hi, rq.q_lo, rq.sub, rq.min_h, rq.scale_h};
    do @(posedge clk_i); while (!s_axis_tready);
    req_count++;
    if (rq.scale_h[14:10] == tbbd_pkg::ExpOnes || rq.min_h[14:10] == tbbd_pkg::ExpOnes)
      special_count++;
    for (int k = 0; k < tbbd_pkg::NumBeats; k++) begin
      qb = (k < 8) ? rq.q_lo[8*k +: 8] : rq.q_hi[8*(k-8) +: 8];
      q  = qb[2*rq.pair +: 2];
      er.value = rq.typed ? rq.typed_val : dequant_value(rq.scale_h, rq.min_h, rq.sub, q);
      er.pos   = 4'(k);
      er.last  = (k == tbbd_pkg::NumBeats - 1);
      pending_q.push_back(er);
    end
  endtask

  // result side: random stalls, with quiet stretches where tready stays high
  always @(posedge clk_i) begin
    deq_res_t er;
    int       stall_left;
    cyc <= cyc + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      res_count++;
      if (pending_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result value=%h pos=%0d", $time,
                 m_axis_tdata[31:0], m_axis_tdata[35:32]);
      end else begin
        er = pending_q.pop_front();
        if (m_axis_tdata[31:0] !== er.value) begin
          err_count++;
          $display("%0t: value pos %0d: expected %h, actual %h", $time, er.pos,
                   er.value, m_axis_tdata[31:0]);
        end
        if (m_axis_tdata[35:32] !== er.pos) begin
          err_count++;
          $display("%0t: position: expected %0d, actual %0d", $time, er.pos,
                   m_axis_tdata[35:32]);
        end
        if (m_axis_tlast !== er.last) begin
          err_count++;
          $display("%0t: tlast pos %0d: expected %b, actual %b", $time, er.pos,
                   er.last, m_axis_tlast);
        end
      end
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (((cyc / 700) % 4) != 3 && $urandom_range(0, 3) == 0) begin
      stall_left = gap_len();
      m_axis_tready <= (stall_left == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog: too long with no request or result accepted
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    req_t rq;
    dir_tab[0]  = '{16'h7C00, 16'h3C00, 8'hFF, '1, '1, 2'd0, 1'b1, 32'h0};        // +Inf scale
    dir_tab[1]  = '{16'h3C00, 16'h7E00, 8'hFF, '1, '1, 2'd1, 1'b1, 32'h0};        // NaN min
    dir_tab[2]  = '{16'hFC00, 16'hFFFF, 8'h37, '1, '0, 2'd2, 1'b1, 32'h0};        // -Inf, NaN
    dir_tab[3]  = '{16'h0000, 16'h0000, 8'hFF, '1, '1, 2'd3, 1'b1, 32'h0};        // zeros
    dir_tab[4]  = '{16'h8000, 16'h0000, 8'hFF, '1, '1, 2'd0, 1'b1, 32'h80000000}; // -0 - +0
    dir_tab[5]  = '{16'h8000, 16'h8000, 8'hFF, '1, '1, 2'd0, 1'b1, 32'h0};        // -0 - -0
    dir_tab[6]  = '{16'h3C00, 16'h0000, 8'h01, '1, '1, 2'd0, 1'b1, 32'h40400000}; // 1*3 - 0
    dir_tab[7]  = '{16'h3C00, 16'h0000, 8'h01, '0, '0, 2'd3, 1'b1, 32'h0};        // q = 0
    dir_tab[8]  = '{16'h3C00, 16'h3C00, 8'h11, 64'h5555555555555555,
                    64'h5555555555555555, 2'd0, 1'b1, 32'h0};                      // 1 - 1
    dir_tab[9]  = '{16'h7BFF, 16'h7BFF, 8'hFF, 64'h0123456789ABCDEF,
                    64'hFEDCBA9876543210, 2'd1, 1'b0, 32'h0};                      // max finite
    dir_tab[10] = '{16'h0001, 16'h0001, 8'hFF, 64'hE4E4E4E4E4E4E4E4,
                    64'h1B1B1B1B1B1B1B1B, 2'd2, 1'b0, 32'h0};                      // min subnormal
    dir_tab[11] = '{16'h03FF, 16'h8400, 8'hF0, '1, '1, 2'd3, 1'b0, 32'h0};
    dir_tab[12] = '{16'hFBFF, 16'h7BFF, 8'hFF, '1, '1, 2'd3, 1'b0, 32'h0};
    dir_tab[13] = '{16'h0400, 16'hFBFF, 8'hF1, 64'hAAAAAAAAAAAAAAAA, '0, 2'd1, 1'b0, 32'h0};
    for (int k = 0; k < 4; k++)                                       // every bit pair
      dir_tab[14 + k] = '{16'h3555, 16'h2AAA, 8'h5A, 64'hE4E4E4E4E4E4E4E4,
                          64'h9C3F06D17B28E5A4, 2'(k), 1'b0, 32'h0};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_req(dir_tab[i]);

    for (int n = 0; n < NumRandom; n++) begin
      rq.scale_h = rand_half();
      rq.min_h   = rand_half();
      rq.sub     = 8'($urandom);
      rq.q_lo    = {$urandom, $urandom};
      rq.q_hi    = {$urandom, $urandom};
      rq.pair    = 2'($urandom);
      rq.typed   = 1'b0;
      rq.typed_val = '0;
      send_req(rq);
      // sender holds off until the pipeline has drained
      if (n == NumRandom / 2) begin
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d requests (%0d with Inf/NaN halves), %0d results checked.",
             req_count, special_count, res_count);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", err_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
